// ===== hdl/sptab_pkg.sv =====
// shared types, constants and helpers for the sorted position mask table
`default_nettype none

package sptab_pkg;

    // table depth and reduction group size
    localparam int SPT_MAX_ENTRIES = 256;
    localparam int SPT_GROUP       = 16;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_LOWER  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // text field count thresholds and reset value
    localparam logic [6:0] TFC_RESET    = 7'd1;
    localparam logic [6:0] TFC_ONE_MAX  = 7'd1;
    localparam logic [6:0] TFC_BYTE_MAX = 7'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] position;
        logic [63:0] text_mask;
        logic [7:0]  entry_index;
    } sptab_in_t;

    typedef struct packed {
        logic        hit;
        logic [8:0]  result_index;
        logic [31:0] result_position;
        logic [63:0] result_mask;
        logic [8:0]  stored_count;
    } sptab_out_t;

    // one stored entry
    typedef struct packed {
        logic [31:0] pos;
        logic [63:0] mask;
    } entry_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic read_mode;
        logic or_en;
        logic ins_en;
    } cell_ctrl_t;

    // mask width kept for the configured number of text fields
    function automatic logic [63:0] cut_mask(input logic [6:0] tfc, input logic [63:0] m);
        logic [63:0] r;
        if (tfc <= TFC_ONE_MAX) begin
            r = 64'd1;
        end else if (tfc <= TFC_BYTE_MAX) begin
            r = {56'd0, m[7:0]};
        end else begin
            r = m;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sptab_cell.sv =====
// one table cell: holds an entry, compares it to the key, shifts from its neighbor
`default_nettype none

module sptab_cell #(
    parameter int CELL_IDX = 0,
    parameter int IW       = 8,
    parameter int CW       = 9
) (
    input  wire logic                 aclk,
    input  wire sptab_pkg::cell_ctrl_t ctrl_i,
    input  wire logic [31:0]          key_i,
    input  wire logic [7:0]           ridx_i,
    input  wire logic [CW-1:0]        count_i,
    input  wire logic [IW-1:0]        upd_idx_i,
    input  wire sptab_pkg::entry_t    wr_ent_i,
    input  wire logic                 prev_lt_i,
    input  wire sptab_pkg::entry_t    prev_ent_i,
    output logic                      lt_o,
    output logic                      sel_o,
    output logic                      eq_o,
    output sptab_pkg::entry_t         ent_o
);
    import sptab_pkg::*;

    localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    entry_t ent_reg;
    logic   lt_reg;
    logic   eq_reg;
    logic   valid;

    // cell holds a live entry
    assign valid = MY_CNT < count_i;

    // key compare
    always_ff @(posedge aclk) begin
        if (ctrl_i.cmp_en) begin
            lt_reg <= valid && (ent_reg.pos < key_i);
            eq_reg <= ent_reg.pos == key_i;
        end
    end

    // shift from left neighbor above the insert point, write at it
    always_ff @(posedge aclk) begin
        if (ctrl_i.ins_en && (MY_IDX > upd_idx_i)) begin
            ent_reg <= prev_ent_i;
        end else if ((ctrl_i.ins_en || ctrl_i.or_en) && (MY_IDX == upd_idx_i)) begin
            ent_reg <= wr_ent_i;
        end
    end

    // select: read by index, or first live cell not below the key
    always_comb begin
        if (ctrl_i.read_mode) begin
            sel_o = valid && (int'(ridx_i) == CELL_IDX);
        end else begin
            sel_o = valid && prev_lt_i && !lt_reg;
        end
    end

    assign lt_o  = lt_reg;
    assign eq_o  = eq_reg;
    assign ent_o = ent_reg;

endmodule

`default_nettype wire

// ===== hdl/sptab_group.sv =====
// registered or-reduction of the selected cell over one group of cells
`default_nettype none

module sptab_group #(
    parameter int GROUP = 16,
    parameter int BASE  = 0,
    parameter int IW    = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           en_i,
    input  wire logic [GROUP-1:0]               sel_i,
    input  wire logic [GROUP-1:0]               eq_i,
    input  wire sptab_pkg::entry_t [GROUP-1:0]  ent_i,
    output logic                                any_o,
    output logic                                eq_o,
    output logic [IW-1:0]                       idx_o,
    output sptab_pkg::entry_t                   ent_o
);
    import sptab_pkg::*;

    logic          any_c;
    logic          eq_c;
    logic [IW-1:0] idx_c;
    entry_t        ent_c;
    logic          any_reg;
    logic          eq_reg;
    logic [IW-1:0] idx_reg;
    entry_t        ent_reg;

    // at most one cell selects, so an or gathers its data
    always_comb begin
        any_c = 1'b0;
        eq_c  = 1'b0;
        idx_c = '0;
        ent_c = '0;
        for (int k = 0; k < GROUP; k++) begin
            if (sel_i[k]) begin
                any_c = 1'b1;
                eq_c  = eq_c | eq_i[k];
                idx_c = idx_c | IW'(BASE + k);
                ent_c = ent_c | ent_i[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            any_reg <= any_c;
            eq_reg  <= eq_c;
            idx_reg <= idx_c;
            ent_reg <= ent_c;
        end
    end

    assign any_o = any_reg;
    assign eq_o  = eq_reg;
    assign idx_o = idx_reg;
    assign ent_o = ent_reg;

endmodule

`default_nettype wire

// ===== hdl/sorted_position_mask_table_core.sv =====
// Sorted (position, field mask) table held in a chain of cells. Every action
// passes through the sequencer from acceptance to the result register: the
// transaction is captured at acceptance, all cells compare against the key,
// the grouped or-reduction of the selected cell is registered (16 cells per
// group), and the groups are merged and the insert shift or mask update is
// applied across the chain as the result is committed. A new transaction is
// accepted in the cycle after the previous one reaches the result register,
// never while one is in flight. The table needs no clearing pass after reset:
// only entries below the stored count are ever selected.
`default_nettype none

module sorted_position_mask_table_core #(
    parameter int MAX_ENTRIES = sptab_pkg::SPT_MAX_ENTRIES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sptab_pkg::sptab_in_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sptab_pkg::sptab_out_t      m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [6:0]            cfg_data
);
    import sptab_pkg::*;

    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int GROUP = SPT_GROUP;
    localparam int NGRP  = (MAX_ENTRIES + GROUP - 1) / GROUP;
    localparam int NPAD  = NGRP * GROUP;
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_ENTRIES);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SEL  = 2'd2;
    localparam logic [1:0] ST_RES  = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    sptab_in_t     item_reg;
    logic [6:0]    tfc_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          m_valid_reg;
    sptab_out_t    m_data_reg;
    sptab_out_t    res;
    logic          res_go;

    cell_ctrl_t    ctrl;
    logic [IW-1:0] upd_idx;
    entry_t        wr_ent;

    logic [NPAD-1:0]  lt_w;
    logic [NPAD-1:0]  sel_w;
    logic [NPAD-1:0]  eq_w;
    entry_t [NPAD-1:0] ent_w;

    logic [NGRP-1:0]  grp_any;
    logic [NGRP-1:0]  grp_eq;
    logic [IW-1:0]    grp_idx [NGRP];
    entry_t [NGRP-1:0] grp_ent;

    logic          f_any;
    logic          f_eq;
    logic [IW-1:0] f_idx;
    entry_t        f_ent;
    logic [CW-1:0] ins_pos;
    logic [63:0]   merged_mask;
    logic [63:0]   new_mask;

    assign cfg_ready = 1'b1;
    assign s_ready   = state_reg == ST_IDLE;
    assign res_go    = (state_reg == ST_RES) && (!m_valid_reg || m_ready);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tfc_reg <= TFC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tfc_reg <= cfg_data;
        end
    end

    // transaction capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_SEL;
            ST_SEL:  state_next = ST_RES;
            ST_RES:  if (res_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // cell chain
    generate
        for (genvar k = 0; k < NPAD; k++) begin : g_cell
            if (k < MAX_ENTRIES) begin : g_live
                logic   prev_lt;
                entry_t prev_ent;
                if (k == 0) begin : g_head
                    assign prev_lt  = 1'b1;
                    assign prev_ent = '0;
                end else begin : g_link
                    assign prev_lt  = lt_w[k-1];
                    assign prev_ent = ent_w[k-1];
                end
                sptab_cell #(
                    .CELL_IDX (k),
                    .IW       (IW),
                    .CW       (CW)
                ) u_cell (
                    .aclk       (aclk),
                    .ctrl_i     (ctrl),
                    .key_i      (item_reg.position),
                    .ridx_i     (item_reg.entry_index),
                    .count_i    (count_reg),
                    .upd_idx_i  (upd_idx),
                    .wr_ent_i   (wr_ent),
                    .prev_lt_i  (prev_lt),
                    .prev_ent_i (prev_ent),
                    .lt_o       (lt_w[k]),
                    .sel_o      (sel_w[k]),
                    .eq_o       (eq_w[k]),
                    .ent_o      (ent_w[k])
                );
            end else begin : g_pad
                assign lt_w[k]  = 1'b0;
                assign sel_w[k] = 1'b0;
                assign eq_w[k]  = 1'b0;
                assign ent_w[k] = '0;
            end
        end

        // grouped reduction of the selected cell
        for (genvar g = 0; g < NGRP; g++) begin : g_grp
            sptab_group #(
                .GROUP (GROUP),
                .BASE  (g * GROUP),
                .IW    (IW)
            ) u_group (
                .aclk  (aclk),
                .en_i  (state_reg == ST_SEL),
                .sel_i (sel_w[g*GROUP +: GROUP]),
                .eq_i  (eq_w[g*GROUP +: GROUP]),
                .ent_i (ent_w[g*GROUP +: GROUP]),
                .any_o (grp_any[g]),
                .eq_o  (grp_eq[g]),
                .idx_o (grp_idx[g]),
                .ent_o (grp_ent[g])
            );
        end
    endgenerate

    // merge of the groups
    always_comb begin
        f_any = 1'b0;
        f_eq  = 1'b0;
        f_idx = '0;
        f_ent = '0;
        for (int g = 0; g < NGRP; g++) begin
            f_any = f_any | grp_any[g];
            f_eq  = f_eq | grp_eq[g];
            f_idx = f_idx | grp_idx[g];
            f_ent = f_ent | grp_ent[g];
        end
    end

    assign merged_mask = cut_mask(tfc_reg, f_ent.mask | item_reg.text_mask);
    assign new_mask    = cut_mask(tfc_reg, item_reg.text_mask);
    assign ins_pos     = f_any ? CW'(f_idx) : count_reg;

    // result and table update
    always_comb begin
        ctrl.cmp_en    = state_reg == ST_CMP;
        ctrl.read_mode = item_reg.action == ACT_READ;
        ctrl.or_en     = 1'b0;
        ctrl.ins_en    = 1'b0;
        upd_idx        = f_idx;
        wr_ent         = '0;
        count_next     = count_reg;
        res.hit             = 1'b0;
        res.result_index    = 9'(count_reg);
        res.result_position = '0;
        res.result_mask     = '0;
        unique case (item_reg.action)
            ACT_INSERT: begin
                if (f_any && f_eq) begin
                    ctrl.or_en          = res_go;
                    wr_ent.pos          = f_ent.pos;
                    wr_ent.mask         = merged_mask;
                    res.hit             = 1'b1;
                    res.result_index    = 9'(f_idx);
                    res.result_position = f_ent.pos;
                    res.result_mask     = merged_mask;
                end else if (f_any || (count_reg != CNT_FULL)) begin
                    ctrl.ins_en         = res_go;
                    upd_idx             = IW'(ins_pos);
                    wr_ent.pos          = item_reg.position;
                    wr_ent.mask         = new_mask;
                    if (count_reg != CNT_FULL) begin
                        count_next = count_reg + CW'(1);
                    end
                    res.hit             = 1'b1;
                    res.result_index    = 9'(ins_pos);
                    res.result_position = item_reg.position;
                    res.result_mask     = new_mask;
                end
            end
            ACT_FIND: begin
                if (f_any && f_eq) begin
                    res.hit             = 1'b1;
                    res.result_index    = 9'(f_idx);
                    res.result_position = f_ent.pos;
                    res.result_mask     = f_ent.mask;
                end
            end
            ACT_LOWER, ACT_READ: begin
                if (f_any) begin
                    res.hit             = 1'b1;
                    res.result_index    = 9'(f_idx);
                    res.result_position = f_ent.pos;
                    res.result_mask     = f_ent.mask;
                end
            end
            default: begin
                res.hit = 1'b0;
            end
        endcase
        res.stored_count = 9'(count_next);
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (res_go) begin
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_go) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // the table never holds more than its depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count beyond table depth");

    // the sorted chain selects at most one group
    a_one_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RES) |-> $onehot0(grp_any))
        else $error("more than one group selected");

    // the count moves only when a result is committed
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !res_go |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside commit");

    // a hit always points inside the held entries
    a_hit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((MAX_ENTRIES > 256) || !m_data.hit ||
                     (m_data.result_index < m_data.stored_count)))
        else $error("hit index outside held entries");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the sorted position mask table core: directed and random transactions
`timescale 1ns / 100ps

module tb;
    import sptab_pkg::*;

    localparam int DEPTH       = SPT_MAX_ENTRIES;
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;

    // receiver stall patterns
    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} ready_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    sptab_in_t   s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    sptab_out_t  m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    // shadow copy of the table and the field count register
    logic [31:0] held_pos  [0:DEPTH-1];
    logic [63:0] held_mask [0:DEPTH-1];
    int          held_count  = 0;
    logic [6:0]  field_count = TFC_RESET;

    sptab_out_t  expected_results [$];
    sptab_out_t  want_result;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;

    ready_mode_t ready_mode      = RDY_ALWAYS;
    int          ready_mode_left = 0;
    int          ready_phase     = 0;

    sorted_position_mask_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // mask width kept for the current field count
    function automatic logic [63:0] kept_mask(input logic [63:0] m);
        if (field_count <= TFC_ONE_MAX)
            return 64'd1;
        if (field_count <= TFC_BYTE_MAX)
            return m & 64'hFF;
        return m;
    endfunction

    // apply one transaction to the shadow table and return the result it yields
    function automatic sptab_out_t predict_table_action(input sptab_in_t req);
        sptab_out_t r;
        int         slot;
        int         j;
        bit         landed;
        slot = 0;
        while (slot < held_count && held_pos[slot] < req.position)
            slot++;
        landed = 1'b0;
        case (req.action)
            ACT_INSERT: begin
                if (slot < held_count && held_pos[slot] == req.position) begin
                    held_mask[slot] = kept_mask(held_mask[slot] | req.text_mask);
                    landed = 1'b1;
                end else if (slot < DEPTH) begin
                    // shift the tail up one place, dropping the top entry when full
                    j = (held_count < DEPTH) ? held_count : DEPTH - 1;
                    while (j > slot) begin
                        held_pos[j]  = held_pos[j-1];
                        held_mask[j] = held_mask[j-1];
                        j--;
                    end
                    held_pos[slot]  = req.position;
                    held_mask[slot] = kept_mask(req.text_mask);
                    if (held_count < DEPTH)
                        held_count++;
                    landed = 1'b1;
                end
            end
            ACT_FIND: begin
                landed = (slot < held_count) && (held_pos[slot] == req.position);
            end
            ACT_LOWER: begin
                landed = slot < held_count;
            end
            ACT_READ: begin
                slot   = req.entry_index;
                landed = slot < held_count;
            end
            default: ;
        endcase
        r.hit          = landed;
        r.stored_count = held_count[8:0];
        if (landed) begin
            r.result_index    = slot[8:0];
            r.result_position = held_pos[slot];
            r.result_mask     = held_mask[slot];
        end else begin
            r.result_index    = held_count[8:0];
            r.result_position = '0;
            r.result_mask     = '0;
        end
        return r;
    endfunction

    function automatic sptab_in_t make_item(input logic [1:0] act, input logic [31:0] pos,
                                            input logic [63:0] mask, input logic [7:0] idx);
        sptab_in_t it;
        it.action      = act;
        it.position    = pos;
        it.text_mask   = mask;
        it.entry_index = idx;
        return it;
    endfunction

    // key mix: spans, extremes, held keys and their neighbors, just above the top
    function automatic logic [31:0] pick_key(input int unsigned span);
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0, 1: k = $urandom;
            2: k = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            3, 4, 5: begin
                if (held_count > 0)
                    k = held_pos[$urandom_range(0, held_count - 1)]
                        + 32'($urandom_range(0, 2)) - 32'd1;
                else
                    k = $urandom_range(0, span);
            end
            6: k = (held_count > 0) ? held_pos[held_count-1] + 32'd1 : 32'd0;
            default: k = $urandom_range(0, span);
        endcase
        return k;
    endfunction

    function automatic logic [63:0] pick_mask();
        logic [63:0] m;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            2: m = 64'd1 << $urandom_range(0, 63);
            default: m = {$urandom, $urandom};
        endcase
        return m;
    endfunction

    function automatic sptab_in_t random_item(input int unsigned span);
        sptab_in_t it;
        int        pick;
        pick           = $urandom_range(0, 9);
        it.action      = (pick < 4) ? ACT_INSERT : (pick < 6) ? ACT_FIND :
                         (pick < 8) ? ACT_LOWER : ACT_READ;
        it.position    = pick_key(span);
        it.text_mask   = pick_mask();
        if ($urandom_range(0, 1) != 0 && held_count > 0)
            it.entry_index = 8'($urandom_range(0, held_count - 1));
        else
            it.entry_index = 8'($urandom);
        return it;
    endfunction

    // send one transaction, with bursts and random gaps
    task automatic send_item(input sptab_in_t item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_results.push_back(predict_table_action(item));
    endtask

    // stop sending and wait for every expected result
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_field_count(input logic [6:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        field_count = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = ready_mode_t'($urandom_range(0, 2));
            ready_mode_left = $urandom_range(40, 200);
        end
        ready_mode_left--;
        ready_phase++;
        case (ready_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_RANDOM:   m_ready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: m_ready <= (ready_phase % 8) >= 3;
            default:      m_ready <= 1'b1;
        endcase
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, m_data);
                mismatches++;
            end else begin
                want_result = expected_results.pop_front();
                if (m_data.hit !== want_result.hit) begin
                    $display("%0t hit expected %h actual %h",
                             $time, want_result.hit, m_data.hit);
                    mismatches++;
                end
                if (m_data.result_index !== want_result.result_index) begin
                    $display("%0t result_index expected %h actual %h",
                             $time, want_result.result_index, m_data.result_index);
                    mismatches++;
                end
                if (m_data.result_position !== want_result.result_position) begin
                    $display("%0t result_position expected %h actual %h",
                             $time, want_result.result_position, m_data.result_position);
                    mismatches++;
                end
                if (m_data.result_mask !== want_result.result_mask) begin
                    $display("%0t result_mask expected %h actual %h",
                             $time, want_result.result_mask, m_data.result_mask);
                    mismatches++;
                end
                if (m_data.stored_count !== want_result.stored_count) begin
                    $display("%0t stored_count expected %h actual %h",
                             $time, want_result.stored_count, m_data.stored_count);
                    mismatches++;
                end
            end
        end
    end

    // searches and reads on the empty table
    task automatic test_empty_table();
        send_item(make_item(ACT_FIND, 32'd0, '0, 8'd0));
        send_item(make_item(ACT_LOWER, 32'd0, '0, 8'd0));
        send_item(make_item(ACT_READ, 32'd0, '0, 8'd0));
    endtask

    // inserts in mixed order, merge into an equal position, hits and misses
    task automatic test_insert_and_search();
        send_item(make_item(ACT_INSERT, 32'd100, '1, 8'd0));
        send_item(make_item(ACT_INSERT, 32'd0, '0, 8'hFF));
        send_item(make_item(ACT_INSERT, 32'hFFFF_FFFF, '0, 8'd0));
        send_item(make_item(ACT_INSERT, 32'd100, 64'h8000_0000_0000_0000, 8'd0));
        send_item(make_item(ACT_FIND, 32'd100, '0, 8'd0));
        send_item(make_item(ACT_FIND, 32'd50, '0, 8'd0));
        send_item(make_item(ACT_LOWER, 32'd50, '0, 8'd0));
        send_item(make_item(ACT_LOWER, 32'hFFFF_FFFF, '0, 8'd0));
        send_item(make_item(ACT_READ, 32'd0, '0, 8'd2));
        send_item(make_item(ACT_READ, 32'd0, '0, 8'd3));
        send_item(make_item(ACT_READ, 32'hFFFF_FFFF, '1, 8'hFF));
    endtask

    // byte, full and single-bit masks, and width changes leaving stored masks alone
    task automatic test_mask_width();
        write_field_count(TFC_BYTE_MAX);
        send_item(make_item(ACT_INSERT, 32'd200, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0));
        send_item(make_item(ACT_INSERT, 32'd200, 64'h0000_0000_0000_5A00, 8'd0));
        write_field_count(7'd64);
        send_item(make_item(ACT_INSERT, 32'd100, 64'hF000_0000_0000_0000, 8'd0));
        write_field_count(7'd0);
        send_item(make_item(ACT_INSERT, 32'd200, '1, 8'd1));
    endtask

    task automatic test_random_traffic(input logic [6:0] tfc, input int count,
                                       input int unsigned span);
        write_field_count(tfc);
        repeat (count) send_item(random_item(span));
    endtask

    // fill the table, then inserts that drop the top entry or the new pair, a merge into the top, and searches
    task automatic test_full_table();
        logic [31:0] key;
        int          j;
        write_field_count(7'd127);
        while (held_count < DEPTH)
            send_item(make_item(ACT_INSERT, $urandom, pick_mask(), 8'($urandom)));
        // fresh keys below the top push the largest entry out
        repeat (2) begin
            key = 32'd0;
            for (j = 0; j < DEPTH - 1; j++)
                if (held_pos[j+1] - held_pos[j] > 32'd1)
                    key = held_pos[j] + 32'd1;
            send_item(make_item(ACT_INSERT, key, pick_mask(), 8'd0));
        end
        key = held_pos[DEPTH-1];
        send_item(make_item(ACT_INSERT, key + 32'd1, '1, 8'd0));
        send_item(make_item(ACT_INSERT, key, pick_mask(), 8'd0));
        send_item(make_item(ACT_READ, 32'd0, '0, 8'hFF));
        send_item(make_item(ACT_FIND, key + 32'd1, '0, 8'd0));
        send_item(make_item(ACT_LOWER, key + 32'd1, '0, 8'd0));
        send_item(make_item(ACT_LOWER, key, '0, 8'd0));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_insert_and_search();
        test_mask_width();
        test_random_traffic(7'd2, 96, 63);
        test_random_traffic(7'd127, 96, 255);
        test_random_traffic(7'd9, 96, 4095);
        test_random_traffic(7'd0, 96, 65535);
        test_full_table();
        test_random_traffic(7'd64, 96, 32'hFFFF_FFFF);
        test_random_traffic(TFC_BYTE_MAX, 96, 32'hFFFF_FFFF);
        test_random_traffic(TFC_ONE_MAX, 96, 32'hFFFF_FFFF);
        test_random_traffic(7'd100, 96, 32'hFFFF_FFFF);

        drain();
        repeat (4 * LATENCY) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sptab_pkg.sv
hdl/sptab_cell.sv
hdl/sptab_group.sv
hdl/sorted_position_mask_table_core.sv
tb/tb.sv
